// ===== hw/rtl/lusa_pkg.sv =====
// shared types and constants for the least-used slot allocator
`timescale 1ns / 1ps
`default_nettype none
package lusa_pkg;

    localparam int MAX_SLOTS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int SCAN_CAP       = 64;
    localparam int SLOT_W         = 6;
    localparam int OUT_CNT_W      = 16;
    localparam int STAT_W         = 2;
    localparam int OP_W           = 2;
    localparam int CPU_W          = 7;
    localparam int IDX_EXT_W      = 9;
    localparam int IN_DATA_W      = 8;
    localparam int OUT_DATA_W     = 24;

    typedef enum logic [OP_W-1:0] {
        OP_TAKE    = 2'd0,
        OP_GIVE    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_UNDER = 2'd2,
        STAT_RSVD  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAKE,
        S_OP_RD,
        S_OP_EX,
        S_RESTART,
        S_DONE
    } t_state;

    typedef struct packed {
        logic we;
        logic clr;
    } t_mem_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/least_used_slot_allocator.sv =====
// least-used slot allocator: per-slot user counts with take, give and restart
//
// Requests arrive on the slave stream (tuser carries the op, tdata the slot and
// keep flag); each request produces exactly one item on the master stream with
// the slot, its count after the request and a status code.
// A take scans the active slots one memory read per cycle through a single
// compare unit, stopping early at a zero count. A give or an unused op passes
// through a read state and an execute state, a restart through a single clear
// state. One request is in flight at a time; tready is high only while the
// sequencer is idle, so the next request can be taken in the cycle after the
// previous result is loaded.
// The result sits in an output register, so the next request is
// accepted while an earlier result still waits; a further result waits in
// the sequencer until the receiver takes the pending one.
// cpu_count is written through i_cfg_we/i_cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce. Reset clears all counts at once through per-slot valid bits, sets cpu_count
// to 1 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module least_used_slot_allocator #(
    parameter int MAX_SLOTS  = lusa_pkg::MAX_SLOTS_DEF,
    parameter int COUNT_BITS = lusa_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lusa_pkg::CPU_W-1:0]      i_cfg_wdata,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [5:0] slot, [6] keep_valid, [7] zero
    input  wire logic [lusa_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] op
    input  wire logic [lusa_pkg::OP_W-1:0]       i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [5:0] granted_slot, [21:6] count_after, [23:22] zero
    output logic      [lusa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic      [lusa_pkg::STAT_W-1:0]     o_m_axis_tuser
);
    import lusa_pkg::*;

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [CPU_W-1:0]      r_cpu_count;
    t_mem_ctl              mem_ctl;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [COUNT_BITS-1:0] wr_data, rd_count;
    logic [SLOT_W-1:0]     out_slot;
    logic [OUT_CNT_W-1:0]  out_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_count <= CPU_W'(1);
        end else if (i_cfg_we) begin
            r_cpu_count <= i_cfg_wdata;
        end
    end

    lusa_mem #(
        .MAX_SLOTS  (MAX_SLOTS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mem_ctl),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_addr  (rd_addr),
        .o_rd_count (rd_count)
    );

    lusa_ctrl #(
        .MAX_SLOTS  (MAX_SLOTS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cpu_count (r_cpu_count),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_slot      (i_s_axis_tdata[SLOT_W-1:0]),
        .i_keep      (i_s_axis_tdata[SLOT_W]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_slot      (out_slot),
        .o_count     (out_cnt),
        .o_status    (o_m_axis_tuser),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_count  (rd_count)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W-OUT_CNT_W-SLOT_W)'(0), out_cnt, out_slot};

endmodule
`default_nettype wire

// ===== hw/rtl/lusa_mem.sv =====
// per-slot user count memory with per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none
module lusa_mem #(
    parameter int MAX_SLOTS  = lusa_pkg::MAX_SLOTS_DEF,
    parameter int COUNT_BITS = lusa_pkg::COUNT_BITS_DEF,
    parameter int IDX_W      = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lusa_pkg::t_mem_ctl    i_ctl,
    input  wire logic [IDX_W-1:0]      i_wr_addr,
    input  wire logic [COUNT_BITS-1:0] i_wr_data,
    input  wire logic [IDX_W-1:0]      i_rd_addr,
    output logic      [COUNT_BITS-1:0] o_rd_count
);
    import lusa_pkg::*;

    logic [COUNT_BITS-1:0] r_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]  r_valid;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // a clear and a write in the same cycle leave the written entry valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_valid <= i_ctl.we ? (MAX_SLOTS'(1) << i_wr_addr) : '0;
            end else if (i_ctl.we) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_count = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/lusa_alu.sv =====
// shared compare and increment/decrement unit
`timescale 1ns / 1ps
`default_nettype none
module lusa_alu #(
    parameter int COUNT_BITS = lusa_pkg::COUNT_BITS_DEF
) (
    input  wire logic [COUNT_BITS-1:0] i_a,
    input  wire logic [COUNT_BITS-1:0] i_b,
    input  wire logic                  i_dec,
    output logic                       o_lt,
    output logic                       o_zero,
    output logic      [COUNT_BITS-1:0] o_step
);
    import lusa_pkg::*;

    assign o_lt   = (i_a < i_b);
    assign o_zero = (i_a == '0);
    assign o_step = i_dec ? (i_a - COUNT_BITS'(1)) : (i_a + COUNT_BITS'(1));

endmodule
`default_nettype wire

// ===== hw/rtl/lusa_ctrl.sv =====
// request sequencer: slot scan, read-modify-write and result register
`timescale 1ns / 1ps
`default_nettype none
module lusa_ctrl #(
    parameter int MAX_SLOTS  = lusa_pkg::MAX_SLOTS_DEF,
    parameter int COUNT_BITS = lusa_pkg::COUNT_BITS_DEF,
    parameter int IDX_W      = 6
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [lusa_pkg::CPU_W-1:0]     i_cpu_count,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [lusa_pkg::OP_W-1:0]      i_op,
    input  wire logic [lusa_pkg::SLOT_W-1:0]    i_slot,
    input  wire logic                           i_keep,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [lusa_pkg::SLOT_W-1:0]    o_slot,
    output logic      [lusa_pkg::OUT_CNT_W-1:0] o_count,
    output logic      [lusa_pkg::STAT_W-1:0]    o_status,
    output lusa_pkg::t_mem_ctl                  o_mem_ctl,
    output logic      [IDX_W-1:0]               o_wr_addr,
    output logic      [COUNT_BITS-1:0]          o_wr_data,
    output logic      [IDX_W-1:0]               o_rd_addr,
    input  wire logic [COUNT_BITS-1:0]          i_rd_count
);
    import lusa_pkg::*;

    localparam int SCAN_LIM = (MAX_SLOTS < SCAN_CAP) ? MAX_SLOTS : SCAN_CAP;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    t_state r_state, n_state;

    t_op                   r_op;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_keep;
    logic                  r_in_range;
    logic [CPU_W-1:0]      r_n, r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [SLOT_W-1:0]     r_chk, r_best, n_best;
    logic [COUNT_BITS-1:0] r_low_cnt, n_low_cnt;

    logic [SLOT_W-1:0]     r_res_slot, n_res_slot;
    logic [OUT_CNT_W-1:0]  r_res_cnt, n_res_cnt;
    t_status               r_res_stat, n_res_stat;

    logic                  r_out_valid;
    logic [SLOT_W-1:0]     r_out_slot;
    logic [OUT_CNT_W-1:0]  r_out_cnt;
    t_status               r_out_stat;

    logic                  accept;
    logic                  out_load;
    logic                  in_range;
    logic [CPU_W-1:0]      active_n;
    logic                  issue;
    logic                  hit;
    logic                  stop;

    logic [COUNT_BITS-1:0] alu_a, alu_b, alu_step;
    logic                  alu_dec, alu_lt, alu_zero;
    logic [COUNT_BITS-1:0] res_cnt_full;

    logic [IDX_EXT_W-1:0]  slot_ext, best_ext, idx_ext;
    logic [OUT_CNT_W+COUNT_BITS-1:0] cnt_ext;

    lusa_alu #(.COUNT_BITS(COUNT_BITS)) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_dec  (alu_dec),
        .o_lt   (alu_lt),
        .o_zero (alu_zero),
        .o_step (alu_step)
    );

    assign accept   = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign slot_ext = {(IDX_EXT_W-SLOT_W)'(0), r_slot};
    assign best_ext = {(IDX_EXT_W-SLOT_W)'(0), r_best};
    assign idx_ext  = {(IDX_EXT_W-CPU_W)'(0), r_idx};
    assign in_range = {(IDX_EXT_W-SLOT_W)'(0), i_slot} < IDX_EXT_W'(MAX_SLOTS);

    // scan length: 0 acts as 1, capped at the scan limit
    always_comb begin
        active_n = i_cpu_count;
        if (active_n == '0) begin
            active_n = CPU_W'(1);
        end
        if (active_n > CPU_W'(SCAN_LIM)) begin
            active_n = CPU_W'(SCAN_LIM);
        end
    end

    // scan step: compare the entry read last cycle, issue the next read
    assign hit   = r_pend && alu_lt;
    assign stop  = hit && alu_zero;
    assign issue = !stop && (r_idx < r_n);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_op))
                        OP_TAKE:    n_state = S_SCAN;
                        OP_RESTART: n_state = S_RESTART;
                        default:    n_state = S_OP_RD;
                    endcase
                end
            end
            S_SCAN: begin
                if (stop || !issue) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE:    n_state = S_DONE;
            S_OP_RD:   n_state = S_OP_EX;
            S_OP_EX:   n_state = S_DONE;
            S_RESTART: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath controls and next values
    always_comb begin
        alu_a        = i_rd_count;
        alu_b        = r_low_cnt;
        alu_dec      = 1'b0;
        o_mem_ctl    = '0;
        o_wr_addr    = best_ext[IDX_W-1:0];
        o_wr_data    = alu_step;
        o_rd_addr    = slot_ext[IDX_W-1:0];
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_best       = r_best;
        n_low_cnt    = r_low_cnt;
        n_res_slot   = r_res_slot;
        n_res_stat   = r_res_stat;
        res_cnt_full = '0;
        n_res_cnt    = r_res_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_idx     = '0;
                n_best    = '0;
                n_low_cnt = COUNT_MAX;
            end
            S_SCAN: begin
                o_rd_addr = idx_ext[IDX_W-1:0];
                if (hit) begin
                    n_best    = r_chk;
                    n_low_cnt = i_rd_count;
                end
                if (issue) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + CPU_W'(1);
                end
            end
            S_TAKE: begin
                alu_a = r_low_cnt;
                alu_b = COUNT_MAX;
                if (alu_lt) begin
                    o_mem_ctl.we = 1'b1;
                    n_res_slot   = r_best;
                    res_cnt_full = alu_step;
                    n_res_stat   = STAT_OK;
                end else begin
                    // every scanned count saturated, slot 0 holds the maximum
                    n_res_slot   = '0;
                    res_cnt_full = COUNT_MAX;
                    n_res_stat   = STAT_FULL;
                end
                n_res_cnt = cnt_ext[OUT_CNT_W-1:0];
            end
            S_OP_RD: begin
                o_rd_addr = slot_ext[IDX_W-1:0];
            end
            S_OP_EX: begin
                alu_dec    = 1'b1;
                o_wr_addr  = slot_ext[IDX_W-1:0];
                n_res_slot = r_slot;
                n_res_stat = STAT_OK;
                if (r_in_range) begin
                    if (r_op == OP_GIVE) begin
                        if (alu_zero) begin
                            n_res_stat = STAT_UNDER;
                        end else begin
                            o_mem_ctl.we = 1'b1;
                            res_cnt_full = alu_step;
                        end
                    end else begin
                        res_cnt_full = i_rd_count;
                    end
                end
                n_res_cnt = cnt_ext[OUT_CNT_W-1:0];
            end
            S_RESTART: begin
                o_mem_ctl.clr = 1'b1;
                o_wr_addr     = slot_ext[IDX_W-1:0];
                o_wr_data     = COUNT_BITS'(1);
                n_res_slot    = r_slot;
                n_res_stat    = STAT_OK;
                if (r_keep && r_in_range) begin
                    o_mem_ctl.we = 1'b1;
                    res_cnt_full = COUNT_BITS'(1);
                end
                n_res_cnt = cnt_ext[OUT_CNT_W-1:0];
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign cnt_ext = {{OUT_CNT_W{1'b0}}, res_cnt_full};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= t_op'(i_op);
            r_slot     <= i_slot;
            r_keep     <= i_keep;
            r_in_range <= in_range;
            r_n        <= active_n;
        end
        r_idx        <= n_idx;
        r_chk        <= r_idx[SLOT_W-1:0];
        r_best       <= n_best;
        r_low_cnt    <= n_low_cnt;
        r_res_slot   <= n_res_slot;
        r_res_cnt    <= n_res_cnt;
        r_res_stat   <= n_res_stat;
        if (out_load) begin
            r_out_slot <= r_res_slot;
            r_out_cnt  <= r_res_cnt;
            r_out_stat <= r_res_stat;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_slot      = r_out_slot;
    assign o_count     = r_out_cnt;
    assign o_status    = r_out_stat;

endmodule
`default_nettype wire
